### src/tdt_pkg.sv
package tdt_pkg;

    localparam int MaxTimers = 16;
    localparam int SlotW     = $clog2(MaxTimers);
    localparam int CntW      = $clog2(MaxTimers + 1);
    localparam int TimeW     = 48;
    localparam int PerW      = 32;
    localparam int ResCap    = 16;
    localparam int CapW      = $clog2(ResCap);
    localparam logic [TimeW-1:0] TMax = {TimeW{1'b1}};
    localparam logic [PerW-1:0] RollReset = 32'd3600000;

    localparam logic [2:0] CmdAdd     = 3'd0;
    localparam logic [2:0] CmdCancel  = 3'd1;
    localparam logic [2:0] CmdRefresh = 3'd2;
    localparam logic [2:0] CmdReset   = 3'd3;
    localparam logic [2:0] CmdExpire  = 3'd4;
    localparam logic [2:0] CmdQuery   = 3'd5;

    // shared arithmetic unit operations
    typedef enum logic [1:0] {
        t_op_add = 2'd0,
        t_op_sub = 2'd1
    } t_op;

    function automatic logic [TimeW-1:0] sat_add(input logic [TimeW-1:0] a,
                                                input logic [TimeW-1:0] b);
        logic [TimeW:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TimeW] ? TMax : s[TimeW-1:0];
    endfunction

endpackage

### src/tdt_alu.sv
module tdt_alu (
    input  tdt_pkg::t_op             i_op,
    input  logic [tdt_pkg::TimeW-1:0] i_a,
    input  logic [tdt_pkg::TimeW-1:0] i_b,
    output logic [tdt_pkg::TimeW-1:0] o_y,
    output logic                      o_lt
);
    import tdt_pkg::*;

    logic [TimeW:0] w_diff;

    // one wide subtractor gives both the compare and the difference
    assign w_diff = {1'b0, i_a} - {1'b0, i_b};
    assign o_lt   = w_diff[TimeW];

    always_comb begin
        case (i_op)
            t_op_add: o_y = sat_add(i_a, i_b);
            t_op_sub: o_y = o_lt ? '0 : w_diff[TimeW-1:0];
            default:  o_y = '0;
        endcase
    end
endmodule

### src/timer_deadline_table.sv
// channel | dir | signals
// in      | in  | i_valid, o_stall, i_cmd/i_now/i_slot_id/i_period/i_repeats/i_restart
// out     | out | o_valid, i_stall, o_ok/o_result_slot/o_fired/o_delay/...
// cfg     | in  | i_cfg_valid, o_cfg_ready, i_cfg_data (rollover_window)
// Cancel, refresh, unchanged reset, full add, unknown and empty expire go from prep straight to emit.
// Add, query, changed reset and expire with nothing due scan all slots through the shared
// add/compare unit; a changed reset first passes through the apply state.
// Expire firing k timers (k at most ResCap): up to k + 1 scans, then k result beats.
// Input stalls until the last result beat is taken.
// Synchronous active-low reset clears active/rearm flags, notice and previous time.
module timer_deadline_table (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_cmd,
    input  logic [47:0] i_now,
    input  logic [3:0]  i_slot_id,
    input  logic [31:0] i_period,
    input  logic        i_repeats,
    input  logic        i_restart,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_ok,
    output logic [3:0]  o_result_slot,
    output logic        o_fired,
    output logic [47:0] o_delay,
    output logic        o_front_notice,
    output logic        o_rollover,
    output logic        o_any_active,
    output logic        o_last
);
    import tdt_pkg::*;

    typedef enum logic [6:0] {
        t_idle  = 7'b0000001,
        t_prep  = 7'b0000010,
        t_scan  = 7'b0000100,
        t_apply = 7'b0001000,
        t_emit  = 7'b0010000,
        t_wait  = 7'b0100000,
        t_fin   = 7'b1000000
    } t_state;

    t_state r_st, n_st;

    logic [TimeW-1:0] r_dl [MaxTimers];
    logic [PerW-1:0]  r_per [MaxTimers];
    logic [MaxTimers-1:0] r_act, r_rearm, r_pick;
    logic r_notice;
    logic [TimeW-1:0] r_prev;
    logic [PerW-1:0]  r_win;

    logic [2:0]       r_cmd;
    logic [TimeW-1:0] r_now;
    logic [SlotW-1:0] r_sid;
    logic [PerW-1:0]  r_nper;
    logic             r_rep, r_fnow;

    logic [SlotW-1:0] r_j;       // scan index
    logic [SlotW-1:0] r_best;
    logic             r_have;
    logic [SlotW-1:0] r_tgt;     // slot under work
    logic [TimeW-1:0] r_tdl;     // deadline of target
    logic             r_front;
    logic             r_roll;
    logic [CntW-1:0]  r_cnt;
    logic             r_okf;
    logic [SlotW-1:0] r_list [ResCap];   // fired slots in deadline order
    logic [CntW-1:0]  r_ei;              // next fired beat to send

    logic             r_ov;
    logic             r_o_ok, r_o_fired, r_o_note, r_o_roll, r_o_last;
    logic [3:0]       r_o_slot;
    logic [TimeW-1:0] r_o_delay;

    t_op              w_op;
    logic [TimeW-1:0] w_a, w_b, w_y;
    logic             w_lt;

    tdt_alu u_alu (.i_op(w_op), .i_a(w_a), .i_b(w_b), .o_y(w_y), .o_lt(w_lt));

    // slot-j compare against best or target: deadline order then index
    logic [TimeW-1:0] w_ref;
    logic [SlotW-1:0] w_refi;
    logic             w_prec, w_eq, w_cand, w_first;
    logic             w_lastj;
    logic             w_noq;

    assign w_lastj = (r_j == SlotW'(MaxTimers - 1));
    assign w_eq    = (r_dl[r_j] == w_ref);

    always_comb begin
        w_ref  = r_have ? r_dl[r_best] : r_tdl;
        w_refi = r_best;
        if (r_cmd == CmdAdd || r_cmd == CmdReset) begin
            w_ref = r_tdl;
            w_refi = r_tgt;
        end
        w_op = t_op_sub;
        w_a  = r_dl[r_j];
        w_b  = w_ref;
        if (r_st == t_prep) begin
            w_op = t_op_add;
            w_a = (r_cmd == CmdReset && !r_fnow) ? r_dl[r_sid] : r_now;
            w_b = (r_cmd == CmdAdd || r_cmd == CmdReset) ? TimeW'(r_nper)
                                                         : TimeW'(r_per[r_sid]);
            if (r_cmd == CmdReset && !r_fnow) begin
                w_op = t_op_sub;
                w_b = TimeW'(r_per[r_sid]);
            end
        end else if (r_st == t_apply) begin
            w_op = t_op_add;
            w_a  = r_now;
            w_b  = (r_cmd == CmdReset) ? TimeW'(r_nper) : TimeW'(r_per[r_best]);
            if (r_cmd == CmdReset)
                w_a = r_tdl;
        end else if (r_st == t_fin) begin
            if (r_cmd == CmdQuery) begin
                // time left, clamped at zero when already due
                w_a = r_dl[r_best];
                w_b = r_now;
            end else begin
                // re-arm of a fired recurring timer
                w_op = t_op_add;
                w_a = r_now;
                w_b = TimeW'(r_per[r_best]);
            end
        end
    end

    assign w_prec = w_lt || (w_eq && r_j < w_refi);
    // expire due test: deadline <= now  (not now < deadline)
    logic [TimeW:0] w_due;
    assign w_due = {1'b0, r_now} - {1'b0, r_dl[r_j]};
    assign w_cand = r_act[r_j] && !r_pick[r_j] && (r_roll || !w_due[TimeW]);
    assign w_first = !r_have;
    assign w_noq = (r_cmd != CmdQuery);

    assign o_stall     = (r_st != t_idle) || r_ov;
    assign o_cfg_ready = (r_st == t_idle);
    assign o_valid     = r_ov;
    assign o_ok        = r_o_ok;
    assign o_result_slot = r_o_slot;
    assign o_fired     = r_o_fired;
    assign o_delay     = r_o_delay;
    assign o_front_notice = r_o_note;
    assign o_rollover  = r_o_roll;
    assign o_any_active = |r_act;
    assign o_last      = r_o_last;

    logic w_sidok;
    assign w_sidok = r_act[r_sid];

    logic [MaxTimers-1:0] w_free;
    logic [SlotW-1:0]     w_fs;
    logic                 w_full;
    always_comb begin
        w_free = ~r_act;
        w_fs = '0;
        for (int k = MaxTimers - 1; k >= 0; k--)
            if (w_free[k]) w_fs = SlotW'(k);
        w_full = (w_free == '0);
    end

    logic w_pend;
    assign w_pend = r_ov && i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= t_idle;
            r_act <= '0;
            r_rearm <= '0;
            r_notice <= 1'b0;
            r_prev <= '0;
            r_win <= RollReset;
            r_ov <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (r_ov && !i_stall) r_ov <= 1'b0;
            if (i_cfg_valid && r_st == t_idle) r_win <= i_cfg_data;
            case (r_st)
                t_idle: begin
                    if (i_valid && !o_stall) begin
                        r_cmd <= i_cmd; r_now <= i_now; r_sid <= i_slot_id;
                        r_nper <= i_period; r_rep <= i_repeats; r_fnow <= i_restart;
                        r_st <= t_prep;
                    end
                end
                t_prep: begin
                    r_j <= '0; r_have <= 1'b0; r_front <= 1'b1; r_pick <= '0;
                    r_cnt <= '0; r_roll <= 1'b0; r_okf <= 1'b0;
                    r_o_slot <= '0; r_o_fired <= 1'b0; r_o_delay <= '0;
                    r_o_note <= 1'b0; r_o_roll <= 1'b0; r_o_last <= 1'b1;
                    r_o_ok <= 1'b1;
                    r_st <= t_emit;
                    case (r_cmd)
                        CmdAdd: begin
                            if (w_full) r_o_ok <= 1'b0;
                            else begin
                                r_act[w_fs] <= 1'b1; r_rearm[w_fs] <= r_rep;
                                r_per[w_fs] <= r_nper; r_dl[w_fs] <= w_y;
                                r_tgt <= w_fs; r_tdl <= w_y; r_o_slot <= w_fs;
                                r_st <= t_scan;
                            end
                        end
                        CmdCancel: begin
                            r_o_ok <= w_sidok;
                            if (w_sidok) r_act[r_sid] <= 1'b0;
                        end
                        CmdRefresh: begin
                            r_o_ok <= w_sidok;
                            if (w_sidok) r_dl[r_sid] <= w_y;
                        end
                        CmdReset: begin
                            r_o_ok <= w_sidok;
                            if (w_sidok && !(r_per[r_sid] == r_nper && !r_fnow)) begin
                                // start: now, or old deadline less old period
                                r_tdl <= r_fnow ? r_now : w_y; r_tgt <= r_sid;
                                r_st <= t_apply;
                            end
                        end
                        CmdExpire: begin
                            if (r_act != '0) begin
                                r_roll <= (r_prev >= TimeW'(r_win)) &&
                                          (r_now < r_prev - TimeW'(r_win));
                                r_prev <= r_now;
                                r_st <= t_scan;
                            end
                        end
                        CmdQuery: begin
                            r_notice <= 1'b0;
                            r_st <= t_scan;
                        end
                        default: r_o_ok <= 1'b0;
                    endcase
                end
                t_apply: begin
                    // reset: start held in r_tdl, new deadline from start + new period
                    r_per[r_tgt] <= r_nper;
                    r_dl[r_tgt] <= w_y;
                    r_tdl <= w_y;
                    r_st <= t_scan;
                end
                t_scan: begin
                    if (!w_noq || r_cmd == CmdExpire) begin
                        if ((r_cmd == CmdExpire ? w_cand : r_act[r_j])
                            && (w_first || w_prec)) begin
                            r_best <= r_j; r_have <= 1'b1;
                        end
                    end else if (r_act[r_j] && r_j != r_tgt && w_prec)
                        r_front <= 1'b0;
                    r_j <= r_j + 1'b1;
                    if (w_lastj) r_st <= t_fin;
                end
                t_fin: begin
                    if (r_cmd == CmdQuery) begin
                        r_o_delay <= r_have ? w_y : TMax;
                        r_st <= t_emit;
                    end else if (r_cmd == CmdExpire) begin
                        if (!r_have || r_cnt == CntW'(ResCap)) begin
                            r_o_roll <= r_roll;
                            r_ei <= '0;
                            r_st <= r_okf ? t_wait : t_emit;
                        end else begin
                            r_pick[r_best] <= 1'b1;
                            r_list[r_cnt[CapW-1:0]] <= r_best;
                            r_cnt <= r_cnt + 1'b1;
                            if (r_rearm[r_best]) r_dl[r_best] <= w_y;
                            else r_act[r_best] <= 1'b0;
                            r_okf <= 1'b1;
                            r_have <= 1'b0; r_j <= '0;
                            r_st <= t_scan;
                        end
                    end else begin
                        if (r_front && !r_notice) begin
                            r_notice <= 1'b1; r_o_note <= 1'b1;
                        end
                        r_st <= t_emit;
                    end
                end
                t_wait: begin
                    // fired beats leave once every pick is done, so any_active is final
                    if (!w_pend) begin
                        r_ov <= 1'b1; r_o_ok <= 1'b1; r_o_fired <= 1'b1;
                        r_o_slot <= r_list[r_ei[CapW-1:0]];
                        r_o_last <= 1'b0;
                        r_ei <= r_ei + 1'b1;
                        if (r_ei + 1'b1 == r_cnt) begin
                            r_o_last <= 1'b1;
                            r_st <= t_idle;
                        end
                    end
                end
                t_emit: begin
                    if (!w_pend) begin
                        r_ov <= 1'b1;
                        r_st <= t_idle;
                    end
                end
                default: r_st <= t_idle;
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == t_emit && !w_pend) |=> r_ov && r_st == t_idle)
        else $error("emit did not present a beat");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CntW'(ResCap))
        else $error("fire count overrun");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st != t_idle) |-> o_stall)
        else $error("input taken while busy");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pend |=> r_ov && $stable({r_o_ok, r_o_slot, r_o_fired, r_o_delay,
                                   r_o_note, r_o_roll, r_o_last}))
        else $error("stalled beat changed");
endmodule
